// ----- rtl/nondominated_front_sorter_macros.svh -----
// assertion macros for the front sorter checker
// no dependencies
`ifndef NONDOMINATED_FRONT_SORTER_MACROS_SVH
`define NONDOMINATED_FRONT_SORTER_MACROS_SVH
// implication checked every clock, quiet during reset
`define NFS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, quiet during reset
`define NFS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- rtl/nfs_pkg.sv -----
// shared types and constants for the nondominated front sorter
// no dependencies
`timescale 1ns / 1ps
package nfs_pkg;
   localparam int POP_SIZE = 32;
   localparam int MAX_OBJECTIVES = 4;
   localparam int NUM_IN_OBJ = 4;
   localparam int IDX_W = $clog2(POP_SIZE);
   localparam int CNT_W = $clog2(POP_SIZE + 1);
   localparam int OBJ_W = 32;
   localparam int ROW_W = MAX_OBJECTIVES * OBJ_W;
   localparam int ACT_MAX = (MAX_OBJECTIVES < NUM_IN_OBJ) ? MAX_OBJECTIVES : NUM_IN_OBJ;

   typedef struct packed {
      logic signed [OBJ_W-1:0] objective_0;
      logic signed [OBJ_W-1:0] objective_1;
      logic signed [OBJ_W-1:0] objective_2;
      logic signed [OBJ_W-1:0] objective_3;
      logic                    final_individual;
   } req_type;

   typedef struct packed {
      logic [4:0] individual_index;
      logic [4:0] front_rank;
      logic       last_of_run;
      logic       overflowed;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic store_item;    // write req item at loaded count
      logic set_ovf;
      logic latch_cfg;     // capture active objective count
      logic clear_run;     // reset count, emitted, mask, front, ovf
      logic start_pass;    // clear dominated vector, i=j=e=0
      logic cmp_step;      // issue pair (i,j) and advance the sweep
      logic emit_step;     // advance emit index
      logic commit_front;  // fold current front into mask
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic last_pair;     // sweep sits on the last pair
      logic emit_hit;      // current emit index is in front
      logic emit_end;      // emit index at the last loaded member
      logic all_done;      // every member assigned after commit
   } dp_stat_type;
endpackage

// ----- rtl/nondominated_front_sorter.sv -----
// Nondominated front sorter: takes one individual per cycle while loading; the
// item flagged final starts the sort and no input is taken until it ends.
// Each front pass sweeps every ordered pair of the n members, then scans the
// members and emits those in the front (a waiting result stalls the scan), so
// n members in f fronts take f such passes.
// Synchronous active-high reset clears control, counts and flags; objectives 2.
`timescale 1ns / 1ps
module nondominated_front_sorter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nfs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nfs_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_wdata
);
   import nfs_pkg::*;

   logic [2:0] num_obj_ff;
   dp_cmd_type cmd;
   dp_stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) num_obj_ff <= 3'd2;
      else if (csr_we) num_obj_ff <= csr_wdata;
   end

   nfs_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_final(req_data.final_individual), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .stat(stat), .cmd(cmd)
   );

   nfs_datapath u_dp (
      .clock(clock), .reset(reset), .req_item(req_data), .num_obj(num_obj_ff),
      .cmd(cmd), .stat(stat), .rsp_item(rsp_data)
   );
endmodule

// ----- rtl/nfs_datapath.sv -----
// datapath: objective row memory, pair compare, front masks and result fields
// depends on nfs_pkg
`timescale 1ns / 1ps
module nfs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  nfs_pkg::req_type     req_item,
   input  logic [2:0]           num_obj,
   input  nfs_pkg::dp_cmd_type  cmd,
   output nfs_pkg::dp_stat_type stat,
   output nfs_pkg::rsp_type     rsp_item
);
   import nfs_pkg::*;

   logic [ROW_W-1:0] obj_mem [POP_SIZE];
   logic [ROW_W-1:0] row_i_ff, row_j_ff;
   logic [ROW_W-1:0] item_row;
   logic [CNT_W-1:0] count_ff, count_in, emitted_ff, emitted_in;
   logic [POP_SIZE-1:0] mask_ff, mask_in, dom_ff, dom_in;
   logic [4:0] front_ff, front_in;
   logic ovf_ff, ovf_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, e_ff, e_in, pi_ff, pi_in;
   logic pv_ff, pv_in;
   logic [2:0] m_ff, m_in, m_act;
   logic [IDX_W-1:0] last_idx;
   logic le_all, eq_all, dominates;

   function automatic logic [OBJ_W-1:0] obj_of(req_type r, int k);
      unique case (k)
         0: obj_of = r.objective_0;
         1: obj_of = r.objective_1;
         2: obj_of = r.objective_2;
         3: obj_of = r.objective_3;
         default: obj_of = '0;
      endcase
   endfunction

   always_comb begin
      item_row = '0;
      for (int k = 0; k < MAX_OBJECTIVES; k++)
         item_row[k*OBJ_W +: OBJ_W] = obj_of(req_item, k);
   end

   always_comb begin
      m_act = num_obj;
      if (num_obj == 3'd0) m_act = 3'd1;
      if (m_act > 3'(ACT_MAX)) m_act = 3'(ACT_MAX);
   end

   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   // one row per individual, both pair rows read with registered data
   always_ff @(posedge clock) begin
      if (cmd.store_item && !stat.full) obj_mem[count_ff[IDX_W-1:0]] <= item_row;
      row_i_ff <= obj_mem[i_ff];
      row_j_ff <= obj_mem[j_ff];
   end

   // j dominates i over the active objectives
   always_comb begin
      le_all = 1'b1;
      eq_all = 1'b1;
      for (int k = 0; k < MAX_OBJECTIVES; k++) begin
         if (k < int'(m_ff)) begin
            if ($signed(row_j_ff[k*OBJ_W +: OBJ_W]) > $signed(row_i_ff[k*OBJ_W +: OBJ_W]))
               le_all = 1'b0;
            if (row_j_ff[k*OBJ_W +: OBJ_W] != row_i_ff[k*OBJ_W +: OBJ_W]) eq_all = 1'b0;
         end
      end
      dominates = le_all && !eq_all;
   end

   always_comb begin
      stat.full = (count_ff == CNT_W'(POP_SIZE));
      stat.last_pair = (i_ff == last_idx) && (j_ff == last_idx);
      stat.emit_hit = !mask_ff[e_ff] && !dom_ff[e_ff];
      stat.emit_end = (e_ff == last_idx);
      stat.all_done = &(mask_ff | ~dom_ff);
      rsp_item.individual_index = 5'(e_ff);
      rsp_item.front_rank = front_ff;
      rsp_item.last_of_run = (emitted_ff + CNT_W'(1) == count_ff);
      rsp_item.overflowed = ovf_ff;
   end

   always_comb begin
      count_in = count_ff; emitted_in = emitted_ff; mask_in = mask_ff; dom_in = dom_ff;
      front_in = front_ff; ovf_in = ovf_ff; i_in = i_ff; j_in = j_ff; e_in = e_ff;
      pi_in = i_ff; pv_in = 1'b0; m_in = m_ff;
      if (cmd.store_item && !stat.full) count_in = count_ff + CNT_W'(1);
      if (cmd.set_ovf) ovf_in = 1'b1;
      if (cmd.latch_cfg) m_in = m_act;
      if (cmd.start_pass) begin
         dom_in = '0; i_in = '0; j_in = '0; e_in = '0;
      end
      if (cmd.cmp_step) begin
         // pairs with an assigned member or a self pair just pass through
         pv_in = !mask_ff[i_ff] && !mask_ff[j_ff] && (i_ff != j_ff);
         if (j_ff == last_idx) begin
            j_in = '0;
            i_in = i_ff + IDX_W'(1);
         end else j_in = j_ff + IDX_W'(1);
      end
      // compare lands in the cycle after the pair is issued
      if (pv_ff && dominates) dom_in[pi_ff] = 1'b1;
      if (cmd.emit_step) begin
         if (stat.emit_hit) emitted_in = emitted_ff + CNT_W'(1);
         e_in = e_ff + IDX_W'(1);
      end
      if (cmd.commit_front) begin
         mask_in = mask_ff | ~dom_ff;
         front_in = front_ff + 5'd1;
      end
      if (cmd.clear_run) begin
         count_in = '0; emitted_in = '0; mask_in = '0; front_in = '0; ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; emitted_ff <= '0; mask_ff <= '0; dom_ff <= '0; front_ff <= '0;
         ovf_ff <= 1'b0; i_ff <= '0; j_ff <= '0; e_ff <= '0; pi_ff <= '0;
         pv_ff <= 1'b0; m_ff <= 3'd2;
      end else begin
         count_ff <= count_in; emitted_ff <= emitted_in; mask_ff <= mask_in;
         dom_ff <= dom_in; front_ff <= front_in; ovf_ff <= ovf_in; i_ff <= i_in;
         j_ff <= j_in; e_ff <= e_in; pi_ff <= pi_in; pv_ff <= pv_in; m_ff <= m_in;
      end
   end
endmodule

// ----- rtl/nfs_controller.sv -----
// controller: load, compare sweep, commit and result emission sequencing
// depends on nfs_pkg
`timescale 1ns / 1ps
module nfs_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_final,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  nfs_pkg::dp_stat_type stat,
   output nfs_pkg::dp_cmd_type  cmd
);
   import nfs_pkg::*;

   localparam logic [2:0] ST_LOAD = 3'd0;
   localparam logic [2:0] ST_INIT = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;
   localparam logic [2:0] ST_CMT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic acc;

   assign req_ready = (state_ff == ST_LOAD);
   assign acc = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_EMIT) && stat.emit_hit;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: if (acc) begin
            cmd.store_item = 1'b1;
            cmd.set_ovf = stat.full;
            if (req_final) begin
               cmd.latch_cfg = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.start_pass = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp_step = 1'b1;
            if (stat.last_pair) state_in = ST_WAIT;
         end
         // last compare still in flight
         ST_WAIT: state_in = ST_EMIT;
         ST_EMIT: if (!stat.emit_hit || rsp_ready) begin
            cmd.emit_step = 1'b1;
            if (stat.emit_end) state_in = ST_CMT;
         end
         ST_CMT: begin
            cmd.commit_front = 1'b1;
            if (stat.all_done) begin
               cmd.clear_run = 1'b1;
               state_in = ST_LOAD;
            end else state_in = ST_INIT;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else state_ff <= state_in;
   end
endmodule

// ----- rtl/nfs_checker.sv -----
// port-level checker for the front sorter, bound to the top level
// depends on nfs_pkg and the macros header
`timescale 1ns / 1ps
`include "nondominated_front_sorter_macros.svh"
module nfs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input nfs_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input nfs_pkg::rsp_type rsp_data
);
   import nfs_pkg::*;
   // no input taken while results are pending
   `NFS_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready, "ready during output")
   // a stalled result holds
   `NFS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed")
   // final input leaves the load phase
   `NFS_ASSERT_NXT(a_final_busy, clock, reset, req_valid && req_ready && req_data.final_individual, !req_ready, "still loading")
endmodule

bind nondominated_front_sorter nfs_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);
